[rtl/strict_base64url_decoder_assert.svh]
// Assertion macros for the unpadded base64url decoder.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef STRICT_BASE64URL_DECODER_ASSERT_SVH
`define STRICT_BASE64URL_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed");

`endif

[rtl/sbd_pkg.sv]
package sbd_pkg;

    typedef enum logic [2:0]
    {
        STATUS_OK        = 3'd0,
        STATUS_FRAMING   = 3'd1,
        STATUS_INVALID   = 3'd2,
        STATUS_TOO_LARGE = 3'd3,
        STATUS_NONCANON  = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        FE_NONE      = 2'd0,
        FE_INVALID   = 2'd1,
        FE_TOO_LARGE = 2'd2
    } first_err_t;

    localparam logic [7:0]  CHAR_PAD      = 8'h3D;
    localparam logic [6:0]  DIGIT_INVALID = 7'd64;
    localparam logic [14:0] COUNT_MAX     = 15'h7FFF;

    typedef struct packed
    {
        logic [7:0] char_code;
        logic       last_char;
    } item_t;

    // eff is the clamped byte limit; char_lim_x is 4*eff+2, against which
    // three times (characters - 2) is compared to avoid a division by three.
    typedef struct packed
    {
        logic [14:0] eff;
        logic [16:0] char_lim_x;
    } limits_t;

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] t;
        begin
            t = 8'd64;
            if (c >= 8'h41 && c <= 8'h5A)
            begin
                t = c - 8'h41;
            end
            else if (c >= 8'h61 && c <= 8'h7A)
            begin
                t = c - 8'h61 + 8'd26;
            end
            else if (c >= 8'h30 && c <= 8'h39)
            begin
                t = c - 8'h30 + 8'd52;
            end
            else if (c == 8'h2D)
            begin
                t = 8'd62;
            end
            else if (c == 8'h5F)
            begin
                t = 8'd63;
            end
            return t[6:0];
        end
    endfunction

endpackage

[rtl/sbd_cfg.sv]
module sbd_cfg
    import sbd_pkg::*;
#(
    parameter int unsigned MAX_DECODED_LIMIT = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [14:0] cfg_data,
    output limits_t     limits
);

    // The register is only 15 bits wide, so a limit above that range never bites.
    localparam int unsigned CLAMP = (MAX_DECODED_LIMIT > 32767) ? 32767 : MAX_DECODED_LIMIT;
    localparam logic [14:0] CLAMP_V = 15'(CLAMP);
    localparam logic [14:0] RESET_EFF = (CLAMP < 1024) ? CLAMP_V : 15'd1024;
    localparam logic [16:0] RESET_LIM = {RESET_EFF, 2'b00} + 17'd2;

    logic [14:0] eff_reg;
    logic [14:0] eff_next;
    logic [16:0] lim_reg;
    logic [16:0] lim_next;

    always_comb
    begin
        eff_next = eff_reg;
        lim_next = lim_reg;
        if (cfg_valid)
        begin
            eff_next = (cfg_data > CLAMP_V) ? CLAMP_V : cfg_data;
            lim_next = {eff_next, 2'b00} + 17'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_reg <= RESET_EFF;
            lim_reg <= RESET_LIM;
        end
        else
        begin
            eff_reg <= eff_next;
            lim_reg <= lim_next;
        end
    end

    assign limits.eff        = eff_reg;
    assign limits.char_lim_x = lim_reg;

endmodule

[rtl/sbd_in_stage.sv]
module sbd_in_stage
    import sbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_ready,
    output item_t item
);

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t hold_item_reg;
    item_t hold_item_next;

    // A new transfer may land when the holding register is empty or the held item leaves in the same cycle.
    assign in_ready = !hold_valid_reg || item_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
            hold_item_next  = in_item;
        end
        else if (item_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

    assign item_valid = hold_valid_reg;
    assign item       = hold_item_reg;

endmodule

[rtl/sbd_core.sv]
module sbd_core
    import sbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  limits_t    limits,
    input  logic       item_valid,
    output logic       item_ready,
    input  item_t      item,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       byte_valid,
    output logic [7:0] data_byte,
    output logic       value_end,
    output logic [2:0] status
);

    logic [5:0]  buf_reg,   buf_next;
    logic [2:0]  bc_reg,    bc_next;
    logic [14:0] cc_reg,    cc_next;
    logic [14:0] bytes_reg, bytes_next;
    logic        fb_reg,    fb_next;
    first_err_t  fe_reg,    fe_next;

    logic        ov_reg,    ov_next;
    logic        bv_reg,    bv_next;
    logic [7:0]  db_reg,    db_next;
    logic        ve_reg,    ve_next;
    status_t     st_reg,    st_next;

    logic        fire;

    assign item_ready = !ov_reg || out_ready;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        logic [6:0]  d;
        logic [11:0] acc;
        logic [14:0] cc_n;
        logic [14:0] bytes_n;
        logic [16:0] cc_x3;
        logic        fb_n;
        logic        frame;
        logic        emit;
        logic [7:0]  byte_n;
        logic [2:0]  bc_n;
        logic [5:0]  buf_n;
        first_err_t  fe_n;

        d       = digit_of(item.char_code);
        acc     = {buf_reg, d[5:0]};
        fb_n    = fb_reg;
        fe_n    = fe_reg;
        bytes_n = bytes_reg;
        bc_n    = bc_reg;
        buf_n   = buf_reg;
        emit    = 1'b0;
        byte_n  = 8'd0;

        if (cc_reg == COUNT_MAX)
        begin
            fb_n = 1'b1;
            cc_n = cc_reg;
        end
        else
        begin
            cc_n = cc_reg + 15'd1;
        end

        // Beyond the character limit when 3*(count-2) exceeds 4*limit+2.
        cc_x3 = ({2'b00, cc_n} << 1) + {2'b00, cc_n} - 17'd6;
        if (cc_n >= 15'd3 && cc_x3 > limits.char_lim_x)
        begin
            fb_n = 1'b1;
        end
        if (item.char_code == CHAR_PAD)
        begin
            fb_n = 1'b1;
        end

        if (!fb_n && fe_reg == FE_NONE)
        begin
            if (d == DIGIT_INVALID)
            begin
                fe_n = FE_INVALID;
            end
            else
            begin
                case (bc_reg)
                    3'd2:
                    begin
                        byte_n = acc[7:0];
                        bc_n   = 3'd0;
                        buf_n  = 6'd0;
                    end
                    3'd4:
                    begin
                        byte_n = acc[9:2];
                        bc_n   = 3'd2;
                        buf_n  = {4'd0, acc[1:0]};
                    end
                    3'd6:
                    begin
                        byte_n = acc[11:4];
                        bc_n   = 3'd4;
                        buf_n  = {2'd0, acc[3:0]};
                    end
                    default:
                    begin
                        bc_n   = 3'd6;
                        buf_n  = acc[5:0];
                    end
                endcase
                if (bc_reg == 3'd2 || bc_reg == 3'd4 || bc_reg == 3'd6)
                begin
                    if (bytes_reg != COUNT_MAX)
                    begin
                        bytes_n = bytes_reg + 15'd1;
                    end
                    if (bytes_n > limits.eff)
                    begin
                        fe_n = FE_TOO_LARGE;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
            end
        end

        frame = fb_n || (cc_n[1:0] == 2'd1);

        buf_next   = buf_reg;
        bc_next    = bc_reg;
        cc_next    = cc_reg;
        bytes_next = bytes_reg;
        fb_next    = fb_reg;
        fe_next    = fe_reg;
        ov_next    = ov_reg && !out_ready;
        bv_next    = bv_reg;
        db_next    = db_reg;
        ve_next    = ve_reg;
        st_next    = st_reg;

        if (fire)
        begin
            ov_next = 1'b1;
            bv_next = emit;
            db_next = emit ? byte_n : 8'd0;
            ve_next = item.last_char;
            st_next = STATUS_OK;
            if (item.last_char)
            begin
                if (frame)
                begin
                    st_next = STATUS_FRAMING;
                end
                else if (fe_n == FE_INVALID)
                begin
                    st_next = STATUS_INVALID;
                end
                else if (fe_n == FE_TOO_LARGE)
                begin
                    st_next = STATUS_TOO_LARGE;
                end
                else if (buf_n != 6'd0)
                begin
                    st_next = STATUS_NONCANON;
                end
                // The stream state starts afresh for the next value.
                buf_next   = 6'd0;
                bc_next    = 3'd0;
                cc_next    = 15'd0;
                bytes_next = 15'd0;
                fb_next    = 1'b0;
                fe_next    = FE_NONE;
            end
            else
            begin
                buf_next   = buf_n;
                bc_next    = bc_n;
                cc_next    = cc_n;
                bytes_next = bytes_n;
                fb_next    = fb_n;
                fe_next    = fe_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= 6'd0;
            bc_reg    <= 3'd0;
            cc_reg    <= 15'd0;
            bytes_reg <= 15'd0;
            fb_reg    <= 1'b0;
            fe_reg    <= FE_NONE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            buf_reg   <= buf_next;
            bc_reg    <= bc_next;
            cc_reg    <= cc_next;
            bytes_reg <= bytes_next;
            fb_reg    <= fb_next;
            fe_reg    <= fe_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bv_reg <= bv_next;
        db_reg <= db_next;
        ve_reg <= ve_next;
        st_reg <= st_next;
    end

    assign out_valid  = ov_reg;
    assign byte_valid = bv_reg;
    assign data_byte  = db_reg;
    assign value_end  = ve_reg;
    assign status     = st_reg;

endmodule

[rtl/strict_base64url_decoder.sv]
// Path: an input transfer is held in the input register, decoded into the result register,
// and offered from there at the output.
// Throughput: one character per cycle while out_ready is high; the decode step between the
// input register and the result register is a digit lookup, a shift and a few compares.
// A result that waits in the result register holds the input side back.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the stream
// state and sets the byte limit to 1024 (or the build limit if smaller).
`include "strict_base64url_decoder_assert.svh"

module strict_base64url_decoder
    import sbd_pkg::*;
#(
    parameter int unsigned MAX_DECODED_LIMIT = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic        value_end,
    output logic [2:0]  status
);

    limits_t limits;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_ready;
    logic    end_with_byte;
    logic    clean_status;

    assign cfg_ready         = 1'b1;
    assign in_item.char_code = char_code;
    assign in_item.last_char = last_char;

    sbd_cfg #(
        .MAX_DECODED_LIMIT(MAX_DECODED_LIMIT)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .limits   (limits)
    );

    sbd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item)
    );

    sbd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .limits    (limits),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item      (item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .byte_valid(byte_valid),
        .data_byte (data_byte),
        .value_end (value_end),
        .status    (status)
    );

    assign end_with_byte = out_valid && byte_valid && value_end;
    assign clean_status  = (status == STATUS_OK) || (status == STATUS_NONCANON);

    // With the result register empty, the input side must never stall.
    `SBD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)
    // A byte that completes on the last character can only come with a clean or
    // non-canonical status: every other error suppresses the byte.
    `SBD_ASSERT_NOW(a_byte_on_end_status, end_with_byte, clean_status)
    // A result is never offered with an error status before the final character.
    `SBD_ASSERT_NOW(a_status_only_at_end, out_valid && !value_end, status == STATUS_OK)
    // Once the result register holds a transfer, it is still there next cycle unless taken.
    `SBD_ASSERT_NEXT(a_result_kept, out_valid && !out_ready, out_valid)

endmodule

[test/strict_base64url_decoder_test.sv]
module strict_base64url_decoder_test
    import sbd_pkg::*;
();

    localparam int unsigned BUILD_LIMIT  = 16384;
    localparam int unsigned RESET_LIMIT  = 1024;
    localparam int          QUIET_LIMIT  = 1000;
    localparam int          RANDOM_CHARS = 500;

    typedef struct packed
    {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       value_end;
        status_t    status;
    } decoded_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = '0;
    logic        last_char = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic        value_end;
    logic [2:0]  status;

    // Shadow of the decoder state, advanced once per accepted character.
    logic [14:0] byte_limit;
    logic [11:0] held_bits;
    logic [2:0]  held_count;
    logic [14:0] chars_seen;
    logic [14:0] bytes_made;
    logic        framing_err;
    first_err_t  stream_err;

    decoded_t predicted[$];
    int       mismatches = 0;
    int       chars_sent = 0;
    bit       steady = 1'b0;

    strict_base64url_decoder #(.MAX_DECODED_LIMIT(BUILD_LIMIT)) dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .value_end  (value_end),
        .status     (status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned effective_limit(input logic [14:0] lim);
        return (lim > BUILD_LIMIT) ? BUILD_LIMIT : lim;
    endfunction

    function automatic void restart_value();
        held_bits   = '0;
        held_count  = '0;
        chars_seen  = '0;
        bytes_made  = '0;
        framing_err = 1'b0;
        stream_err  = FE_NONE;
    endfunction

    function automatic decoded_t decode_char(input logic [7:0] c, input logic last);
        decoded_t    r;
        int unsigned eff;
        int unsigned char_lim;
        int unsigned digit;
        int unsigned acc;
        int unsigned nbits;
        r = '0;
        eff = effective_limit(byte_limit);
        char_lim = (eff * 4 + 2) / 3 + 2;
        if (c >= "A" && c <= "Z")
            digit = c - "A";
        else if (c >= "a" && c <= "z")
            digit = c - "a" + 26;
        else if (c >= "0" && c <= "9")
            digit = c - "0" + 52;
        else if (c == "-")
            digit = 62;
        else if (c == "_")
            digit = 63;
        else
            digit = 64;

        // A saturated character counter means the value is far too long.
        if (chars_seen == COUNT_MAX)
            framing_err = 1'b1;
        else
            chars_seen++;
        if (chars_seen > char_lim)
            framing_err = 1'b1;
        if (c == CHAR_PAD)
            framing_err = 1'b1;

        if (!framing_err && stream_err == FE_NONE)
        begin
            if (digit > 63)
            begin
                stream_err = FE_INVALID;
            end
            else
            begin
                acc = ((held_bits << 6) | digit) & 32'hFFF;
                nbits = held_count + 6;
                if (nbits >= 8)
                begin
                    nbits -= 8;
                    if (bytes_made != COUNT_MAX)
                        bytes_made++;
                    if (bytes_made > eff)
                    begin
                        stream_err = FE_TOO_LARGE;
                    end
                    else
                    begin
                        r.byte_valid = 1'b1;
                        r.data_byte = 8'(acc >> nbits);
                    end
                end
                held_count = 3'(nbits);
                held_bits = 12'(acc & ((32'd1 << nbits) - 1));
            end
        end

        if (last)
        begin
            r.value_end = 1'b1;
            if (chars_seen[1:0] == 2'd1)
                framing_err = 1'b1;
            if (framing_err)
                r.status = STATUS_FRAMING;
            else if (stream_err == FE_INVALID)
                r.status = STATUS_INVALID;
            else if (stream_err == FE_TOO_LARGE)
                r.status = STATUS_TOO_LARGE;
            else if (held_count != 0 && held_bits != 0)
                r.status = STATUS_NONCANON;
            else
                r.status = STATUS_OK;
            restart_value();
        end
        return r;
    endfunction

    function automatic logic [7:0] alpha_char(input int unsigned d);
        if (d < 26)
            return 8'("A" + d);
        else if (d < 52)
            return 8'("a" + d - 26);
        else if (d < 62)
            return 8'("0" + d - 52);
        else if (d == 62)
            return "-";
        else
            return "_";
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatches++;
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= last;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        predicted.insert(predicted.size(), decode_char(c, last));
        chars_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted.size() != 0) @(posedge clk);
    endtask

    task automatic write_limit(input logic [14:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        byte_limit = v;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    // Random alphabet content (noise_pct percent replaced by noise); where bits are left over, about half end clean.
    task automatic send_random_value(input int len, input int noise_pct);
        logic [7:0]  c;
        int unsigned d;
        for (int i = 0; i < len; i++)
        begin
            d = $urandom_range(0, 63);
            if (i == len - 1 && $urandom_range(0, 1))
            begin
                if (len % 4 == 2)
                    d = d & 'h30;
                else if (len % 4 == 3)
                    d = d & 'h3C;
            end
            c = alpha_char(d);
            if ($urandom_range(0, 99) < noise_pct)
                c = ($urandom_range(0, 7) == 0) ? CHAR_PAD : 8'($urandom_range(0, 255));
            send_char(c, i == len - 1);
        end
    endtask

    task automatic probe_length_edges();
        int unsigned char_lim;
        int unsigned len;
        char_lim = (effective_limit(byte_limit) * 4 + 2) / 3 + 2;
        if (char_lim > 40)
        begin
            repeat (3) send_random_value($urandom_range(2, 12), 0);
        end
        else
        begin
            len = (char_lim > 4) ? char_lim - 3 : 1;
            steady = (char_lim > 24);
            while (len <= char_lim + 1)
            begin
                send_random_value(len, 0);
                len++;
            end
            steady = 1'b0;
        end
    endtask

    task automatic test_directed();
        send_text("Zg");
        send_text("Zh");
        send_text("_-_-");
        send_text("09az");
        send_text("A");
        send_text("AB=");
        // Characters after an invalid one must not produce bytes.
        send_text("Q*QQQQ");
        // A pad outranks an earlier invalid character.
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CHAR_PAD, 1'b1);
    endtask

    task automatic test_byte_limits();
        logic [14:0] settings[$];
        settings = '{15'd0, 15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd24,
                     15'($urandom_range(6, 20)), 15'd16384, 15'd16385, 15'd32767,
                     15'(RESET_LIMIT)};
        probe_length_edges();
        foreach (settings[k])
        begin
            write_limit(settings[k]);
            probe_length_edges();
        end
    endtask

    task automatic test_random_values();
        int start;
        int pick;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                write_limit(15'($urandom_range(0, 40)));
            else if (pick < 12)
                write_limit(15'($urandom_range(41, 32767)));
            else if (pick < 16)
                wait_drained();
            steady = ($urandom_range(0, 4) == 0);
            send_random_value($urandom_range(1, 24), ($urandom_range(0, 3) == 0) ? 15 : 0);
        end
        steady = 1'b0;
    endtask

    task automatic test_long_values();
        write_limit(15'd16385);
        steady = 1'b1;
        send_random_value(60, 0);
        send_random_value(61, 0);
        steady = 1'b0;
    endtask

    // Each output transfer is matched against the oldest prediction.
    initial
    begin : result_check
        int       stall;
        decoded_t want;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            if (predicted.size() == 0)
            begin
                $error("result transfer with no character waiting for it");
                mismatches++;
            end
            else
            begin
                want = predicted.pop_front();
                compare_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                compare_field("data_byte", want.data_byte, data_byte);
                compare_field("value_end", 8'(want.value_end), 8'(value_end));
                compare_field("status", 8'(want.status), 8'(status));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        byte_limit = RESET_LIMIT;
        restart_value();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_byte_limits();
        test_random_values();
        test_long_values();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
